// ----- rtl/sflc_pkg.sv -----
package sflc_pkg;

    localparam int MAX_FRAME_DEF     = 64;
    localparam int ERASE_SECTORS_DEF = 15;

    localparam int BYTE_W    = 8;
    localparam int ADDR_W    = 16;
    localparam int CNT_W     = 9;
    localparam int IDX_W     = 6;
    localparam int CFG_IDX_W = 2;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_TUSER_W = 3;

    localparam logic [ADDR_W-1:0] ERASE_BASE  = 16'hE200;
    localparam int                ERASE_SHIFT = 9;
    localparam logic [ADDR_W-1:0] FINAL_ADDR  = 16'hFFE0;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_BYTE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ERASE_OK    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHECKSUM_ER = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PROGRAM_OK  = 2'd3;

    typedef enum logic [1:0] {
        KIND_ERASE = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_REPLY = 2'd2,
        KIND_RESET = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        OUT_ERASE,
        OUT_WRITE,
        OUT_EOK,
        OUT_CERR,
        OUT_POK,
        OUT_RST
    } t_out_sel;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RST,
        ST_ERASE,
        ST_EOK,
        ST_HDR0,
        ST_HDR1,
        ST_HDR2,
        ST_PAYLOAD,
        ST_DRAIN,
        ST_CERR,
        ST_WFETCH,
        ST_WRITE,
        ST_POK,
        ST_HALT
    } t_state;

    typedef struct packed {
        logic     cap_hi;
        logic     cap_lo;
        logic     cap_len;
        logic     pay_acc;
        logic     drain_acc;
        logic     idx_clr;
        logic     idx_inc;
        logic     ram_re;
        logic     out_load;
        t_out_sel out_sel;
        logic     out_last;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic mode_ok;
        logic len_bad;
        logic len_one;
        logic pay_end;
        logic xor_ok;
        logic drain_end;
        logic erase_last;
        logic write_last;
        logic frame_fin;
    } t_stat;

endpackage

// ----- rtl/sflc_ram.sv -----
module sflc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/sflc_ctrl.sv -----
module sflc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_action,
    output logic          o_ready,
    input  sflc_pkg::t_stat i_stat,
    output sflc_pkg::t_cmd  o_cmd
);
    import sflc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid && i_action == ACT_START) begin
                    if (i_stat.mode_ok) begin
                        o_cmd.idx_clr = 1'b1;
                        n_state       = ST_ERASE;
                    end else begin
                        n_state = ST_RST;
                    end
                end
            end
            ST_RST: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OUT_RST;
                    o_cmd.out_last = 1'b1;
                    n_state        = ST_HALT;
                end
            end
            ST_ERASE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OUT_ERASE;
                    o_cmd.idx_inc  = 1'b1;
                    if (i_stat.erase_last) begin
                        n_state = ST_EOK;
                    end
                end
            end
            ST_EOK: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OUT_EOK;
                    o_cmd.out_last = 1'b1;
                    n_state        = ST_HDR0;
                end
            end
            ST_HDR0: begin
                o_ready = 1'b1;
                if (i_valid && i_action == ACT_BYTE) begin
                    o_cmd.cap_hi = 1'b1;
                    n_state      = ST_HDR1;
                end
            end
            ST_HDR1: begin
                o_ready = 1'b1;
                if (i_valid && i_action == ACT_BYTE) begin
                    o_cmd.cap_lo = 1'b1;
                    n_state      = ST_HDR2;
                end
            end
            ST_HDR2: begin
                o_ready = 1'b1;
                if (i_valid && i_action == ACT_BYTE) begin
                    o_cmd.cap_len = 1'b1;
                    n_state       = i_stat.len_bad ? ST_DRAIN : ST_PAYLOAD;
                end
            end
            ST_PAYLOAD: begin
                o_ready = 1'b1;
                if (i_valid && i_action == ACT_BYTE) begin
                    o_cmd.pay_acc = 1'b1;
                    if (i_stat.pay_end) begin
                        if (!i_stat.xor_ok) begin
                            n_state = ST_CERR;
                        end else if (i_stat.len_one) begin
                            n_state = ST_POK;
                        end else begin
                            o_cmd.idx_clr = 1'b1;
                            n_state       = ST_WFETCH;
                        end
                    end
                end
            end
            ST_DRAIN: begin
                o_ready = 1'b1;
                if (i_valid && i_action == ACT_BYTE) begin
                    o_cmd.drain_acc = 1'b1;
                    if (i_stat.drain_end) begin
                        n_state = ST_CERR;
                    end
                end
            end
            ST_CERR: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OUT_CERR;
                    o_cmd.out_last = 1'b1;
                    n_state        = ST_HDR0;
                end
            end
            ST_WFETCH: begin
                o_cmd.ram_re = 1'b1;
                n_state      = ST_WRITE;
            end
            ST_WRITE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OUT_WRITE;
                    o_cmd.idx_inc  = 1'b1;
                    o_cmd.ram_re   = 1'b1;
                    if (i_stat.write_last) begin
                        n_state = ST_POK;
                    end
                end
            end
            ST_POK: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OUT_POK;
                    o_cmd.out_last = 1'b1;
                    n_state        = i_stat.frame_fin ? ST_HALT : ST_HDR0;
                end
            end
            ST_HALT: begin
                o_ready = 1'b1;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_stat.out_free)
        else $error("result loaded while output register busy");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_HALT |=> r_state == ST_HALT)
        else $error("left halt without reset");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.pay_acc |-> (i_valid && o_ready && i_action == ACT_BYTE))
        else $error("payload stored without an accepted byte");

endmodule

// ----- rtl/sflc_dp.sv -----
module sflc_dp #(
    parameter int MAX_FRAME     = sflc_pkg::MAX_FRAME_DEF,
    parameter int ERASE_SECTORS = sflc_pkg::ERASE_SECTORS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  sflc_pkg::t_cmd                     i_cmd,
    output sflc_pkg::t_stat                    o_stat,
    input  logic [sflc_pkg::BYTE_W-1:0]        i_byte,
    input  logic                               i_cfg_we,
    input  logic [sflc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sflc_pkg::BYTE_W-1:0]        i_cfg_data,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [sflc_pkg::OUT_TDATA_W-1:0]   o_out_tdata,
    output logic [sflc_pkg::OUT_TUSER_W-1:0]   o_out_tuser,
    output logic                               o_out_tlast
);
    import sflc_pkg::*;

    localparam int AW = $clog2(MAX_FRAME);

    logic [BYTE_W-1:0] r_entry_mode;
    logic [BYTE_W-1:0] r_erase_ok;
    logic [BYTE_W-1:0] r_cksum_err;
    logic [BYTE_W-1:0] r_prog_ok;

    logic [ADDR_W-1:0] r_addr;
    logic [BYTE_W-1:0] r_len;
    logic [CNT_W-1:0]  r_cnt;
    logic [BYTE_W-1:0] r_xor;
    logic [IDX_W-1:0]  r_idx;

    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_tdata;
    logic [OUT_TUSER_W-1:0] r_out_tuser;
    logic                   r_out_tlast;

    logic [CNT_W-1:0]  w_cnt_inc;
    logic [CNT_W-1:0]  w_drain_total;
    logic [IDX_W-1:0]  w_idx_inc;
    logic [AW-1:0]     w_raddr;
    logic [BYTE_W-1:0] w_rdata;
    logic [ADDR_W-1:0] w_erase_addr;
    logic              w_fin;
    t_kind             w_kind;
    logic [ADDR_W-1:0] w_oaddr;
    logic [BYTE_W-1:0] w_odata;

    assign w_cnt_inc     = CNT_W'(r_cnt + CNT_W'(1));
    assign w_drain_total = (r_len == '0) ? CNT_W'(256) : {1'b0, r_len};
    assign w_idx_inc     = IDX_W'(r_idx + IDX_W'(1));
    assign w_raddr       = i_cmd.idx_inc ? w_idx_inc[AW-1:0] : r_idx[AW-1:0];
    assign w_erase_addr  = ADDR_W'(ERASE_BASE + (ADDR_W'(r_idx) << ERASE_SHIFT));
    assign w_fin         = (r_addr == FINAL_ADDR);

    always_comb begin
        o_stat.out_free   = !r_out_valid || i_out_ready;
        o_stat.mode_ok    = (i_byte == r_entry_mode);
        o_stat.len_bad    = (i_byte == '0) || ({1'b0, i_byte} > CNT_W'(MAX_FRAME));
        o_stat.len_one    = (r_len == BYTE_W'(1));
        o_stat.pay_end    = (w_cnt_inc >= {1'b0, r_len});
        o_stat.xor_ok     = (r_xor == i_byte);
        o_stat.drain_end  = (w_cnt_inc >= w_drain_total);
        o_stat.erase_last = (r_idx == IDX_W'(ERASE_SECTORS - 1));
        o_stat.write_last = ({2'b00, r_idx} == BYTE_W'(r_len - BYTE_W'(2)));
        o_stat.frame_fin  = w_fin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_mode <= '0;
            r_erase_ok   <= '0;
            r_cksum_err  <= '0;
            r_prog_ok    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ENTRY_MODE:  r_entry_mode <= i_cfg_data;
                REG_ERASE_OK:    r_erase_ok   <= i_cfg_data;
                REG_CHECKSUM_ER: r_cksum_err  <= i_cfg_data;
                REG_PROGRAM_OK:  r_prog_ok    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // frame header, byte counter, running checksum and result index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
            r_len  <= '0;
            r_cnt  <= '0;
            r_xor  <= '0;
            r_idx  <= '0;
        end else begin
            if (i_cmd.cap_hi) begin
                r_addr[ADDR_W-1:BYTE_W] <= i_byte;
            end
            if (i_cmd.cap_lo) begin
                r_addr[BYTE_W-1:0] <= i_byte;
            end
            if (i_cmd.cap_len) begin
                r_len <= i_byte;
                r_cnt <= '0;
                r_xor <= '0;
            end
            if (i_cmd.pay_acc) begin
                r_cnt <= w_cnt_inc;
                r_xor <= r_xor ^ i_byte;
            end
            if (i_cmd.drain_acc) begin
                r_cnt <= w_cnt_inc;
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= w_idx_inc;
            end
        end
    end

    sflc_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_FRAME)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (i_cmd.pay_acc),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (i_byte),
        .i_re    (i_cmd.ram_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        w_kind  = KIND_REPLY;
        w_oaddr = '0;
        w_odata = '0;
        unique case (i_cmd.out_sel)
            OUT_ERASE: begin
                w_kind  = KIND_ERASE;
                w_oaddr = w_erase_addr;
            end
            OUT_WRITE: begin
                w_kind  = KIND_WRITE;
                w_oaddr = ADDR_W'(r_addr + ADDR_W'(r_idx));
                w_odata = w_rdata;
            end
            OUT_EOK:  w_odata = r_erase_ok;
            OUT_CERR: w_odata = r_cksum_err;
            OUT_POK:  w_odata = r_prog_ok;
            OUT_RST:  w_kind  = KIND_RESET;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_tdata <= {w_odata, w_oaddr};
            r_out_tuser <= {(i_cmd.out_sel == OUT_POK) && w_fin, w_kind};
            r_out_tlast <= i_cmd.out_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_tdata = r_out_tdata;
    assign o_out_tuser = r_out_tuser;
    assign o_out_tlast = r_out_tlast;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pay_acc |-> (r_cnt < CNT_W'(MAX_FRAME)))
        else $error("payload write beyond buffer");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_load && i_cmd.out_sel == OUT_WRITE) |-> (r_len > BYTE_W'(1)))
        else $error("byte write issued for a frame without data");

endmodule

// ----- rtl/serial_flash_loader_frame_checker_top.sv -----
// serial flash loader frame checker
// input channel s_axis: tuser[0] is the action (0 start with a mode byte,
// 1 received serial byte), tdata[7:0] is the byte
// output channel m_axis: tdata holds the flash address in [15:0] and the
// data or reply code in [23:16]; tuser[1:0] is the kind (erase, write,
// reply, reset request), tuser[2] asks for reset after the final reply;
// tlast marks the last result caused by one input beat
// config: i_cfg_we writes i_cfg_data into register i_cfg_index (entry mode,
// erase ok, checksum error, program ok); the user writes only while idle, not enforced
// an input beat that causes no result leaves the input ready; a start beat gives
// ERASE_SECTORS erases and a reply (or a reset request for a wrong mode byte), a
// closing payload beat up to MAX_FRAME-1 writes and a reply, at one result per
// cycle while the receiver is ready; writes follow a read on the single read port
// results leave through one output register; a stalled receiver holds it
// and the sequencer waits, input is not taken while the sequencer still
// has results to issue
// reset is synchronous and returns the block to waiting for a start beat
module serial_flash_loader_frame_checker_top #(
    parameter int MAX_FRAME     = sflc_pkg::MAX_FRAME_DEF,
    parameter int ERASE_SECTORS = sflc_pkg::ERASE_SECTORS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,  // byte_value
    input  logic [0:0]                       s_axis_tuser,  // action
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [sflc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // out_address, out_data
    output logic [sflc_pkg::OUT_TUSER_W-1:0] m_axis_tuser,  // out_kind, reset_after
    output logic                             m_axis_tlast,
    input  logic                             i_cfg_we,
    input  logic [sflc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sflc_pkg::BYTE_W-1:0]      i_cfg_data
);
    import sflc_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    sflc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_action (s_axis_tuser[0]),
        .o_ready  (s_axis_tready),
        .i_stat   (w_stat),
        .o_cmd    (w_cmd)
    );

    sflc_dp #(
        .MAX_FRAME     (MAX_FRAME),
        .ERASE_SECTORS (ERASE_SECTORS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_byte      (s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_tdata (m_axis_tdata),
        .o_out_tuser (m_axis_tuser),
        .o_out_tlast (m_axis_tlast)
    );

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import sflc_pkg::*;

    localparam logic [15:0] ERASE_START     = 16'hE200;
    localparam logic [15:0] ERASE_STRIDE    = 16'h0200;
    localparam logic [15:0] LAST_FRAME_ADDR = 16'hFFE0;
    localparam int          CYCLE_LIMIT     = 300000;

    typedef enum logic [2:0] {
        LD_IDLE,
        LD_HEADER,
        LD_PAYLOAD,
        LD_DRAIN,
        LD_HALT
    } t_ld_phase;

    typedef struct packed {
        logic       act;
        logic [7:0] val;
    } t_loader_beat;

    typedef struct {
        t_kind       kind;
        logic [15:0] addr;
        logic [7:0]  data;
        logic        rst_after;
        logic        last;
    } t_flash_op;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata = 8'h00;  // byte_value
    logic [0:0]             s_axis_tuser = 1'b0;   // action
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;          // out_address, out_data
    logic [OUT_TUSER_W-1:0] m_axis_tuser;          // out_kind, reset_after
    logic                   m_axis_tlast;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = REG_ENTRY_MODE;
    logic [BYTE_W-1:0]      i_cfg_data = 8'h00;

    serial_flash_loader_frame_checker_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // loader state as seen by the checker
    t_ld_phase   ld_phase = LD_IDLE;
    logic [1:0]  hdr_idx = 2'd0;
    logic [15:0] frm_addr = 16'h0000;
    logic [7:0]  frm_len = 8'h00;
    logic [8:0]  rx_cnt = 9'd0;
    logic [7:0]  run_xor = 8'h00;
    logic [7:0]  pay_buf [64];
    logic [7:0]  code_reg [4] = '{default: 8'h00};

    t_loader_beat rx_beats_q [$];
    t_flash_op    flash_ops_q [$];
    int           fails = 0;
    int           cycles = 0;
    int           beat_gap_pct = 0;
    int           sink_stall_pct = 0;
    int           beat_gap = 0;
    int           sink_stall = 0;

    function automatic t_flash_op mk_op(t_kind k, logic [15:0] a, logic [7:0] d, logic r);
        t_flash_op o;
        o.kind = k;
        o.addr = a;
        o.data = d;
        o.rst_after = r;
        o.last = 1'b0;
        return o;
    endfunction

    function automatic void loader_step(logic act, logic [7:0] b);
        t_flash_op   ops [$];
        int unsigned drain_len;
        if (act == ACT_START) begin
            if (ld_phase == LD_IDLE) begin
                if (b != code_reg[REG_ENTRY_MODE]) begin
                    ops.push_back(mk_op(KIND_RESET, 16'h0000, 8'h00, 1'b0));
                    ld_phase = LD_HALT;
                end else begin
                    for (int i = 0; i < ERASE_SECTORS_DEF; i++)
                        ops.push_back(mk_op(KIND_ERASE, ERASE_START + 16'(i) * ERASE_STRIDE,
                                            8'h00, 1'b0));
                    ops.push_back(mk_op(KIND_REPLY, 16'h0000, code_reg[REG_ERASE_OK], 1'b0));
                    ld_phase = LD_HEADER;
                    hdr_idx = 2'd0;
                end
            end
        end else begin
            case (ld_phase)
                LD_HEADER: begin
                    if (hdr_idx == 2'd0) begin
                        frm_addr[15:8] = b;
                        hdr_idx = 2'd1;
                    end else if (hdr_idx == 2'd1) begin
                        frm_addr[7:0] = b;
                        hdr_idx = 2'd2;
                    end else begin
                        frm_len = b;
                        rx_cnt = 9'd0;
                        run_xor = 8'h00;
                        hdr_idx = 2'd0;
                        ld_phase = (b == 8'h00 || b > MAX_FRAME_DEF) ? LD_DRAIN : LD_PAYLOAD;
                    end
                end
                LD_PAYLOAD: begin
                    pay_buf[rx_cnt[5:0]] = b;
                    rx_cnt = rx_cnt + 9'd1;
                    if (rx_cnt >= {1'b0, frm_len}) begin
                        ld_phase = LD_HEADER;
                        if (run_xor != b) begin
                            ops.push_back(mk_op(KIND_REPLY, 16'h0000,
                                                code_reg[REG_CHECKSUM_ER], 1'b0));
                        end else begin
                            for (int i = 0; i < frm_len - 1; i++)
                                ops.push_back(mk_op(KIND_WRITE, frm_addr + 16'(i), pay_buf[i],
                                                    1'b0));
                            ops.push_back(mk_op(KIND_REPLY, 16'h0000, code_reg[REG_PROGRAM_OK],
                                                frm_addr == LAST_FRAME_ADDR));
                            if (frm_addr == LAST_FRAME_ADDR)
                                ld_phase = LD_HALT;
                        end
                    end else begin
                        run_xor = run_xor ^ b;
                    end
                end
                LD_DRAIN: begin
                    drain_len = (frm_len == 8'h00) ? 256 : frm_len;
                    rx_cnt = rx_cnt + 9'd1;
                    if (rx_cnt >= drain_len) begin
                        ops.push_back(mk_op(KIND_REPLY, 16'h0000,
                                            code_reg[REG_CHECKSUM_ER], 1'b0));
                        ld_phase = LD_HEADER;
                    end
                end
                default: ;
            endcase
        end
        foreach (ops[i]) begin
            ops[i].last = (i == ops.size() - 1);
            flash_ops_q.push_back(ops[i]);
        end
    endfunction

    // source side
    always @(posedge i_clk) begin : drv
        t_loader_beat nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                loader_step(s_axis_tuser[0], s_axis_tdata);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (beat_gap > 0) begin
                    beat_gap <= beat_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if ($urandom_range(0, 99) < beat_gap_pct) begin
                    beat_gap <= $urandom_range(0, 6);
                    s_axis_tvalid <= 1'b0;
                end else if (rx_beats_q.size() > 0) begin
                    nxt = rx_beats_q.pop_front();
                    s_axis_tuser <= nxt.act;
                    s_axis_tdata <= nxt.val;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // sink side
    always @(posedge i_clk) begin : mon
        t_flash_op want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (flash_ops_q.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected beat, actual kind %0d addr %h data %h rst %b last %b",
                             $time, m_axis_tuser[1:0], m_axis_tdata[15:0], m_axis_tdata[23:16],
                             m_axis_tuser[2], m_axis_tlast);
                end else begin
                    want = flash_ops_q.pop_front();
                    if (m_axis_tuser[1:0] !== want.kind || m_axis_tdata[15:0] !== want.addr ||
                        m_axis_tdata[23:16] !== want.data || m_axis_tuser[2] !== want.rst_after ||
                        m_axis_tlast !== want.last) begin
                        fails++;
                        $display("%0t: expected kind %0d addr %h data %h rst %b last %b",
                                 $time, want.kind, want.addr, want.data, want.rst_after,
                                 want.last);
                        $display("%0t:   actual kind %0d addr %h data %h rst %b last %b",
                                 $time, m_axis_tuser[1:0], m_axis_tdata[15:0],
                                 m_axis_tdata[23:16], m_axis_tuser[2], m_axis_tlast);
                    end
                end
            end
            if (sink_stall > 0) begin
                sink_stall <= sink_stall - 1;
                m_axis_tready <= 1'b0;
            end else if ($urandom_range(0, 99) < sink_stall_pct) begin
                sink_stall <= $urandom_range(0, 6);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic void queue_beat(logic act, logic [7:0] b);
        t_loader_beat t;
        t.act = act;
        t.val = b;
        rx_beats_q.push_back(t);
    endfunction

    function automatic void queue_frame(logic [15:0] addr, logic [7:0] len, bit good);
        logic [7:0] sum;
        logic [7:0] b;
        sum = 8'h00;
        queue_beat(ACT_BYTE, addr[15:8]);
        queue_beat(ACT_BYTE, addr[7:0]);
        queue_beat(ACT_BYTE, len);
        if (len == 8'h00 || len > MAX_FRAME_DEF) begin
            repeat ((len == 8'h00) ? 256 : len) queue_beat(ACT_BYTE, 8'($urandom));
        end else begin
            repeat (len - 1) begin
                b = 8'($urandom);
                sum = sum ^ b;
                queue_beat(ACT_BYTE, b);
            end
            queue_beat(ACT_BYTE, good ? sum : sum ^ 8'($urandom_range(1, 255)));
        end
    endfunction

    function automatic logic [15:0] pick_addr();
        logic [15:0] a;
        if ($urandom_range(0, 3) == 0)
            a = 16'($urandom_range(16'hFFC0, 16'hFFFF));
        else
            a = 16'($urandom);
        if (a == LAST_FRAME_ADDR)
            a = a ^ 16'h0001;
        return a;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        code_reg[idx] = val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_codes(logic [7:0] mode, logic [7:0] eok, logic [7:0] cerr,
                               logic [7:0] pok);
        write_reg(REG_ENTRY_MODE, mode);
        write_reg(REG_ERASE_OK, eok);
        write_reg(REG_CHECKSUM_ER, cerr);
        write_reg(REG_PROGRAM_OK, pok);
    endtask

    task automatic wait_quiet();
        do @(posedge i_clk);
        while (rx_beats_q.size() != 0 || s_axis_tvalid || flash_ops_q.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    initial begin : stim
        int          sel;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_codes(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));

        // directed
        beat_gap_pct = 20;
        sink_stall_pct = 20;
        queue_beat(ACT_BYTE, 8'hFF);
        queue_beat(ACT_BYTE, 8'h00);
        queue_beat(ACT_START, code_reg[REG_ENTRY_MODE]);
        queue_beat(ACT_START, ~code_reg[REG_ENTRY_MODE]);
        queue_frame(16'h0000, 8'd1, 1'b1);
        queue_frame(16'hFFFF, 8'd1, 1'b0);
        queue_frame(16'hFFFF, 8'd3, 1'b1);
        queue_frame(LAST_FRAME_ADDR, 8'd4, 1'b0);
        queue_frame(16'h1234, 8'd65, 1'b1);
        wait_quiet();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: write_codes(8'h00, 8'h00, 8'h00, 8'h00);
                1: write_codes(8'hFF, 8'hFF, 8'hFF, 8'hFF);
                default: write_codes(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            endcase
            sel = $urandom_range(0, 2);
            beat_gap_pct = (ph == 3) ? 0 : (sel == 0) ? 0 : (sel == 1) ? 15 : 40;
            sel = $urandom_range(0, 2);
            sink_stall_pct = (ph == 3) ? 0 : (sel == 0) ? 0 : (sel == 1) ? 15 : 40;
            while (rx_beats_q.size() < 5) begin
                sel = $urandom_range(0, 99);
                if (sel < 60) begin
                    queue_frame(pick_addr(), 8'($urandom_range(1, 8)), 1'b1);
                end else if (sel < 85) begin
                    queue_frame(pick_addr(), 8'($urandom_range(1, 8)), 1'b0);
                end else begin
                    queue_beat(ACT_START, 8'($urandom));
                end
            end
            if (ph == 3) begin
                // closing frame halts the loader, later beats are dropped
                queue_frame(LAST_FRAME_ADDR, 8'($urandom_range(1, 6)), 1'b1);
                queue_beat(ACT_START, code_reg[REG_ENTRY_MODE]);
                queue_beat(ACT_BYTE, 8'($urandom));
            end
            wait_quiet();
        end

        if (fails == 0 && flash_ops_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/sflc_pkg.sv
rtl/sflc_ram.sv
rtl/sflc_ctrl.sv
rtl/sflc_dp.sv
rtl/serial_flash_loader_frame_checker_top.sv
test/tb.sv
